[sv/braub_pkg.sv]
// ----------------------------------------------------------------------------
// braub_pkg
// shared opcodes, widths and types of the bytecode register alu/branch unit
// ----------------------------------------------------------------------------
package braub_pkg;

  localparam int unsigned NumRegs = 6;
  localparam int unsigned RegIdxW = 3;
  localparam int unsigned DataW   = 64;
  localparam int unsigned KindW   = 6;

  typedef enum logic [KindW-1:0] {
    OP_MOV    = 6'd8,
    OP_LDI    = 6'd10,
    OP_ADD    = 6'd11,
    OP_SUB    = 6'd12,
    OP_MUL    = 6'd13,
    OP_DIV    = 6'd14,
    OP_BEQ1   = 6'd15,
    OP_BEQ0   = 6'd16,
    OP_BLT0   = 6'd17,
    OP_BGT0   = 6'd18,
    OP_BNE1   = 6'd19,
    OP_BNE0   = 6'd20,
    OP_BGE0   = 6'd21,
    OP_BLE0   = 6'd22,
    OP_JMP    = 6'd23,
    OP_BOOL   = 6'd24,
    OP_AND    = 6'd25,
    OP_OR     = 6'd26,
    OP_NOT    = 6'd27,
    OP_PRINT  = 6'd50,
    OP_LDI2   = 6'd51
  } opcode_e;

  // classified operation handed from front to back
  typedef enum logic [3:0] {
    CL_NOP, CL_MOV, CL_LDI, CL_ADD, CL_SUB, CL_MUL, CL_DIV,
    CL_BR, CL_BOOL, CL_AND, CL_OR, CL_NOT, CL_PRINT
  } op_class_e;

  typedef struct packed {
    op_class_e          op;
    logic [KindW-1:0]   kind;
    logic [RegIdxW-1:0] src;
    logic [RegIdxW-1:0] dst;
    logic [DataW-1:0]   imm;
  } uop_t;

  typedef struct packed {
    logic             branch_taken;
    logic [DataW-1:0] branch_offset;
    logic             print_valid;
    logic [DataW-1:0] print_value;
    logic             status;
  } result_t;

endpackage

[sv/braub_if.sv]
// ----------------------------------------------------------------------------
// braub_in_if / braub_out_if
// valid/ready channels carrying instructions and results
// ----------------------------------------------------------------------------
interface braub_in_if;
  logic                             valid;
  logic                             ready;
  logic [braub_pkg::KindW-1:0]      kind;
  logic [braub_pkg::RegIdxW-1:0]    src_reg;
  logic [braub_pkg::RegIdxW-1:0]    dst_reg;
  logic signed [braub_pkg::DataW-1:0] immediate;
  modport source (output valid, kind, src_reg, dst_reg, immediate, input ready);
  modport sink   (input valid, kind, src_reg, dst_reg, immediate, output ready);
endinterface

interface braub_out_if;
  logic                               valid;
  logic                               ready;
  logic                               branch_taken;
  logic signed [braub_pkg::DataW-1:0] branch_offset;
  logic                               print_valid;
  logic signed [braub_pkg::DataW-1:0] print_value;
  logic                               status;
  modport source (output valid, branch_taken, branch_offset, print_valid, print_value,
                  status, input ready);
  modport sink   (input valid, branch_taken, branch_offset, print_valid, print_value,
                  status, output ready);
endinterface

[sv/braub_front.sv]
// ----------------------------------------------------------------------------
// braub_front
// accepts instructions, decodes them and pushes them into a two-entry queue
// ----------------------------------------------------------------------------
module braub_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  braub_in_if.sink             in_i,
  output braub_pkg::uop_t      uop_o,
  output logic                 uop_valid_o,
  input  logic                 uop_pop_i
);

  braub_pkg::uop_t  fifo_q [2];
  logic             wp_q, rp_q;
  logic [1:0]       cnt_q;
  braub_pkg::uop_t  dec;
  logic             push;

  always_comb begin
    dec.kind = in_i.kind;
    dec.src  = in_i.src_reg;
    dec.dst  = in_i.dst_reg;
    dec.imm  = in_i.immediate;
    unique case (in_i.kind)
      braub_pkg::OP_MOV:                       dec.op = braub_pkg::CL_MOV;
      braub_pkg::OP_LDI, braub_pkg::OP_LDI2:   dec.op = braub_pkg::CL_LDI;
      braub_pkg::OP_ADD:                       dec.op = braub_pkg::CL_ADD;
      braub_pkg::OP_SUB:                       dec.op = braub_pkg::CL_SUB;
      braub_pkg::OP_MUL:                       dec.op = braub_pkg::CL_MUL;
      braub_pkg::OP_DIV:                       dec.op = braub_pkg::CL_DIV;
      braub_pkg::OP_BEQ1, braub_pkg::OP_BEQ0, braub_pkg::OP_BLT0, braub_pkg::OP_BGT0,
      braub_pkg::OP_BNE1, braub_pkg::OP_BNE0, braub_pkg::OP_BGE0, braub_pkg::OP_BLE0,
      braub_pkg::OP_JMP:                       dec.op = braub_pkg::CL_BR;
      braub_pkg::OP_BOOL:                      dec.op = braub_pkg::CL_BOOL;
      braub_pkg::OP_AND:                       dec.op = braub_pkg::CL_AND;
      braub_pkg::OP_OR:                        dec.op = braub_pkg::CL_OR;
      braub_pkg::OP_NOT:                       dec.op = braub_pkg::CL_NOT;
      braub_pkg::OP_PRINT:                     dec.op = braub_pkg::CL_PRINT;
      default:                                 dec.op = braub_pkg::CL_NOP;
    endcase
  end

  assign in_i.ready  = (cnt_q != 2'd2);
  assign push        = in_i.valid && in_i.ready;
  assign uop_valid_o = (cnt_q != 2'd0);
  assign uop_o       = fifo_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wp_q] <= dec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (uop_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, uop_pop_i};
    end
  end

endmodule

[sv/braub_back.sv]
// ----------------------------------------------------------------------------
// braub_back
// register file, alu with sequential multiplier/divider, result register
// ----------------------------------------------------------------------------
module braub_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  braub_pkg::uop_t uop_i,
  input  logic            uop_valid_i,
  output logic            uop_pop_o,
  braub_out_if.source     out_o
);

  localparam int unsigned W = braub_pkg::DataW;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_e;

  state_e              state_q, state_d;
  logic [W-1:0]        rf_q [braub_pkg::NumRegs];
  logic [W-1:0]        s, d;
  logic                dneg;
  logic                taken;
  braub_pkg::result_t  res_q;
  logic                ovalid_q;
  logic                out_free;

  // iterative unit: 64 steps of one bit
  logic [W-1:0]        acc_q, opa_q, opb_q;
  logic [W-1:0]        rem_q;
  logic [5:0]          cnt_q;
  logic                qneg_q;
  logic [W:0]          trial;
  logic [W-1:0]        rem_sh;

  always_comb begin
    s = (uop_i.src < braub_pkg::RegIdxW'(braub_pkg::NumRegs)) ? rf_q[uop_i.src] : '0;
    d = (uop_i.dst < braub_pkg::RegIdxW'(braub_pkg::NumRegs)) ? rf_q[uop_i.dst] : '0;
  end
  assign dneg = d[W-1];

  always_comb begin
    unique case (uop_i.kind)
      braub_pkg::OP_BEQ1: taken = (d == W'(1));
      braub_pkg::OP_BEQ0: taken = (d == '0);
      braub_pkg::OP_BLT0: taken = dneg;
      braub_pkg::OP_BGT0: taken = !dneg && d != '0;
      braub_pkg::OP_BNE1: taken = (d != W'(1));
      braub_pkg::OP_BNE0: taken = (d != '0);
      braub_pkg::OP_BGE0: taken = !dneg;
      braub_pkg::OP_BLE0: taken = dneg || d == '0;
      braub_pkg::OP_JMP:  taken = 1'b1;
      default:            taken = 1'b0;
    endcase
  end

  assign out_free     = !ovalid_q || out_o.ready;
  assign rem_sh       = {rem_q[W-2:0], opa_q[W-1]};
  assign trial        = {1'b0, rem_sh} - {1'b0, opb_q};

  always_comb begin
    state_d   = state_q;
    uop_pop_o = 1'b0;
    unique case (state_q)
      ST_IDLE: if (uop_valid_i && out_free) begin
        if (uop_i.op == braub_pkg::CL_MUL) state_d = ST_MUL;
        else if (uop_i.op == braub_pkg::CL_DIV && s != '0) state_d = ST_DIV;
        else uop_pop_o = 1'b1;
      end
      ST_MUL, ST_DIV: if (cnt_q == 6'd63) state_d = ST_FIN;
      ST_FIN: begin
        uop_pop_o = 1'b1;
        state_d   = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // iterative datapath
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE) begin
      acc_q  <= '0;
      rem_q  <= '0;
      cnt_q  <= '0;
      qneg_q <= d[W-1] ^ s[W-1];
      if (uop_i.op == braub_pkg::CL_MUL) begin
        opa_q <= d;
        opb_q <= s;
      end else begin
        opa_q <= d[W-1] ? -d : d;
        opb_q <= s[W-1] ? -s : s;
      end
    end else if (state_q == ST_MUL) begin
      // shift-add, lsb first
      if (opa_q[0]) acc_q <= acc_q + opb_q;
      opa_q <= opa_q >> 1;
      opb_q <= opb_q << 1;
      cnt_q <= cnt_q + 6'd1;
    end else if (state_q == ST_DIV) begin
      // restoring division, msb first; quotient bits enter acc
      if (!trial[W]) begin
        rem_q <= trial[W-1:0];
        acc_q <= {acc_q[W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        acc_q <= {acc_q[W-2:0], 1'b0};
      end
      opa_q <= opa_q << 1;
      cnt_q <= cnt_q + 6'd1;
    end
  end

  logic          wr_en;
  logic [W-1:0]  wr_val;

  always_comb begin
    wr_en  = 1'b0;
    wr_val = '0;
    if (state_q == ST_FIN) begin
      wr_en  = 1'b1;
      wr_val = (uop_i.op == braub_pkg::CL_DIV && qneg_q) ? -acc_q : acc_q;
    end else if (state_q == ST_IDLE && uop_pop_o) begin
      unique case (uop_i.op)
        braub_pkg::CL_MOV:  begin wr_en = 1'b1; wr_val = s; end
        braub_pkg::CL_LDI:  begin wr_en = 1'b1; wr_val = uop_i.imm; end
        braub_pkg::CL_ADD:  begin wr_en = 1'b1; wr_val = d + s; end
        braub_pkg::CL_SUB:  begin wr_en = 1'b1; wr_val = d - s; end
        braub_pkg::CL_BOOL: begin wr_en = 1'b1; wr_val = W'(s != '0); end
        braub_pkg::CL_AND:  begin wr_en = 1'b1; wr_val = W'(s != '0 && d != '0); end
        braub_pkg::CL_OR:   begin wr_en = 1'b1; wr_val = W'(s != '0 || d != '0); end
        braub_pkg::CL_NOT:  begin wr_en = 1'b1; wr_val = W'(s == '0); end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < braub_pkg::NumRegs; i++) rf_q[i] <= '0;
    end else if (wr_en && uop_i.dst < braub_pkg::RegIdxW'(braub_pkg::NumRegs)) begin
      rf_q[uop_i.dst] <= wr_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (uop_pop_o) ovalid_q <= 1'b1;
      else if (out_o.ready) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (uop_pop_o) begin
      res_q.branch_taken  <= taken;
      res_q.branch_offset <= taken ? uop_i.imm : '0;
      res_q.print_valid   <= (uop_i.op == braub_pkg::CL_PRINT);
      res_q.print_value   <= (uop_i.op == braub_pkg::CL_PRINT) ? s : '0;
      res_q.status        <= (uop_i.op == braub_pkg::CL_DIV && s == '0);
    end
  end

  assign out_o.valid         = ovalid_q;
  assign out_o.branch_taken  = res_q.branch_taken;
  assign out_o.branch_offset = res_q.branch_offset;
  assign out_o.print_valid   = res_q.print_valid;
  assign out_o.print_value   = res_q.print_value;
  assign out_o.status        = res_q.status;

endmodule

[sv/bytecode_register_alu_branch_unit.sv]
// ----------------------------------------------------------------------------
// bytecode_register_alu_branch_unit
// executes one bytecode instruction per request against six 64-bit registers
// ----------------------------------------------------------------------------
// A request is decoded in the front and queued (two entries), then executed
// by the back, which reads and writes the register file and fills a result
// register. Simple operations and branches complete in the back end's idle
// state, so the unit sustains one request per cycle for them while the
// output is ready; multiply and divide run a shared one-bit-per-cycle shift
// unit and hold the back end until its finish state. Divide by zero sets
// status and completes at once. The register file is cleared by reset.
module bytecode_register_alu_branch_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  braub_in_if.sink    in_i,
  braub_out_if.source out_o
);

  braub_pkg::uop_t uop;
  logic            uop_valid, uop_pop;

  braub_front u_front (
    .clk_i, .rst_ni, .in_i,
    .uop_o(uop), .uop_valid_o(uop_valid), .uop_pop_i(uop_pop)
  );

  braub_back u_back (
    .clk_i, .rst_ni, .uop_i(uop), .uop_valid_i(uop_valid),
    .uop_pop_o(uop_pop), .out_o
  );

  a_pop_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    uop_pop |-> uop_valid) else $error("pop of empty queue");

  a_pop_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    uop_pop |=> out_o.valid) else $error("result lost");

  a_not_taken_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.branch_taken) |-> out_o.branch_offset == '0)
    else $error("offset without branch");

endmodule
